// ----- rtl/core/record_sort_by_grade_defines.svh -----
// Assertion macros shared by the record sort block.
`ifndef RECORD_SORT_BY_GRADE_DEFINES_SVH
`define RECORD_SORT_BY_GRADE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define RSG_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence holds in the same cycle.
`define RSG_ASSERT_SAME(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// When the trigger holds, the consequence holds in the next cycle.
`define RSG_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/rsg_pkg.sv -----
// Types and constants of the record sort block.
package rsg_pkg;

	localparam logic [13:0] GRADE_TOP = 14'd10000;

	typedef struct packed {
		logic [15:0] record_id;
		logic [13:0] grade_hundredths;
		logic        last_record;
	} in_t;

	typedef struct packed {
		logic [15:0] sorted_id;
		logic [13:0] sorted_grade;
		logic        end_of_run;
		logic        overflow_flag;
	} out_t;

	typedef struct packed {
		logic [15:0] id;
		logic [13:0] grade;
	} rec_t;

	typedef struct packed {
		logic load;
		logic step;
	} step_ctrl_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_START = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_END   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

endpackage

// ----- rtl/core/rsg_store.sv -----
// Record store: one write port and one registered read port.
module rsg_store #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  rsg_pkg::rec_t            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output rsg_pkg::rec_t            rdata
);

	rsg_pkg::rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/rsg_step.sv -----
// Compare-exchange unit that carries the sinking record through one pass.
module rsg_step (
	input  logic                clk,
	input  rsg_pkg::step_ctrl_t ctrl,
	input  rsg_pkg::rec_t       rd,
	output rsg_pkg::rec_t       wr
);

	rsg_pkg::rec_t carry_q;
	logic          lower;

	// Swap only on a strictly lower grade so that equal grades keep their order.
	assign lower = carry_q.grade < rd.grade;
	assign wr = (ctrl.step && lower) ? rd : carry_q;

	always_ff @(posedge clk) begin
		if (ctrl.load || (ctrl.step && !lower)) begin
			carry_q <= rd;
		end
	end

endmodule

// ----- rtl/core/record_sort_by_grade.sv -----
// Top level of the record sort block: loader, sort sequencer and emitter.
//
// Usage: records are offered on item with start. A beat is taken at a rising
// edge where start is high and busy is low. Each record is stored at the
// edge that takes it, and busy stays low while a set is being loaded. A grade
// above 100.00 is stored as 100.00. Records beyond MAX_RECORDS are dropped
// and the set is marked as overflowed.
// The beat with last_record set ends the set. busy then rises and the set
// is sorted by grade, highest first, with equal grades in arrival order.
// The sort does one compare-exchange per cycle on the single compare unit,
// with a closing step per pass to retire the sinking record, all bound by
// the one store read port. The run is then emitted one beat per cycle, each
// beat marked by result_strobe for exactly one cycle. end_of_run flags the
// final beat and overflow_flag is the same on every beat of the run. The
// receiver cannot stall: a beat is taken in the cycle it is shown. busy
// falls in the cycle that shows the final beat, so the next set may begin
// right away.
// Reset clears the record count, the overflow mark and the sequencer; the
// store contents are not cleared, since only written entries are read.
module record_sort_by_grade #(
	parameter int MAX_RECORDS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rsg_pkg::in_t  item,
	output logic          busy,
	output logic          result_strobe,
	output rsg_pkg::out_t result
);

	`include "record_sort_by_grade_defines.svh"

	localparam int IDX_W = $clog2(MAX_RECORDS);
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

	rsg_pkg::state_t     state_q;
	logic [CNT_W-1:0]    count_q;
	logic                dropped_q;
	logic [IDX_W-1:0]    lim_q;
	logic [IDX_W-1:0]    ridx_q;
	logic [IDX_W-1:0]    eidx_q;
	logic                strobe_s1;
	logic                last_s1;
	logic                ovf_s1;

	logic                accept;
	logic                room;
	logic                emit_last;
	logic [IDX_W-1:0]    count_last;
	rsg_pkg::rec_t       in_rec;
	rsg_pkg::rec_t       rd_rec;
	rsg_pkg::rec_t       step_wr;
	rsg_pkg::step_ctrl_t step_ctrl;

	logic                we;
	logic [IDX_W-1:0]    waddr;
	rsg_pkg::rec_t       wdata;
	logic [IDX_W-1:0]    raddr;

	assign busy   = (state_q != rsg_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign room   = (count_q < CNT_MAX);

	// Grades above full marks are clipped as they are stored.
	assign in_rec.id    = item.record_id;
	assign in_rec.grade = (item.grade_hundredths > rsg_pkg::GRADE_TOP) ?
		rsg_pkg::GRADE_TOP : item.grade_hundredths;

	assign count_last = IDX_W'(count_q - CNT_ONE);
	assign emit_last  = (eidx_q == count_last);

	// The first cycle of a pass loads the carry with entry 0; each later
	// cycle compares the carry against the next entry and writes back the
	// winner one place lower.
	assign step_ctrl.load = (state_q == rsg_pkg::ST_RUN) && (ridx_q == '0);
	assign step_ctrl.step = (state_q == rsg_pkg::ST_RUN) && (ridx_q != '0);

	always_comb begin
		we    = 1'b0;
		waddr = count_q[IDX_W-1:0];
		wdata = in_rec;
		raddr = '0;
		unique case (state_q)
			rsg_pkg::ST_IDLE: begin
				we = accept && room;
			end
			rsg_pkg::ST_START: begin
				raddr = '0;
			end
			rsg_pkg::ST_RUN: begin
				// Read one entry ahead of the one being compared.
				raddr = (ridx_q == lim_q) ? ridx_q : ridx_q + IDX_ONE;
				we    = (ridx_q != '0);
				waddr = ridx_q - IDX_ONE;
				wdata = step_wr;
			end
			rsg_pkg::ST_END: begin
				// The carry has sunk to the end of this pass. Entry 0 is read
				// for the next pass at the same time.
				we    = 1'b1;
				waddr = lim_q;
				wdata = step_wr;
			end
			rsg_pkg::ST_EMIT: begin
				raddr = eidx_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	rsg_store #(
		.DEPTH(MAX_RECORDS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_rec)
	);

	rsg_step u_step (
		.clk (clk),
		.ctrl(step_ctrl),
		.rd  (rd_rec),
		.wr  (step_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rsg_pkg::ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			lim_q     <= '0;
			ridx_q    <= '0;
			eidx_q    <= '0;
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
			ovf_s1    <= 1'b0;
		end else begin
			strobe_s1 <= (state_q == rsg_pkg::ST_EMIT);
			last_s1   <= emit_last;
			ovf_s1    <= dropped_q;
			unique case (state_q)
				rsg_pkg::ST_IDLE: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + CNT_ONE;
						end else begin
							dropped_q <= 1'b1;
						end
						if (item.last_record) begin
							state_q <= rsg_pkg::ST_START;
						end
					end
				end
				rsg_pkg::ST_START: begin
					lim_q  <= count_last;
					ridx_q <= '0;
					eidx_q <= '0;
					if (count_q == CNT_ONE) begin
						state_q <= rsg_pkg::ST_EMIT;
					end else begin
						state_q <= rsg_pkg::ST_RUN;
					end
				end
				rsg_pkg::ST_RUN: begin
					ridx_q <= ridx_q + IDX_ONE;
					if (ridx_q == lim_q) begin
						state_q <= rsg_pkg::ST_END;
					end
				end
				rsg_pkg::ST_END: begin
					ridx_q <= '0;
					eidx_q <= '0;
					if (lim_q == IDX_ONE) begin
						state_q <= rsg_pkg::ST_EMIT;
					end else begin
						lim_q   <= lim_q - IDX_ONE;
						state_q <= rsg_pkg::ST_RUN;
					end
				end
				rsg_pkg::ST_EMIT: begin
					eidx_q <= eidx_q + IDX_ONE;
					if (emit_last) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
						state_q   <= rsg_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rsg_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// The result beat comes straight from the registered store read.
	assign result_strobe        = strobe_s1;
	assign result.sorted_id     = rd_rec.id;
	assign result.sorted_grade  = rd_rec.grade;
	assign result.end_of_run    = last_s1;
	assign result.overflow_flag = ovf_s1;

	`RSG_ASSERT_ALWAYS(a_count_in_range, count_q <= CNT_MAX, "record count beyond store size")
	`RSG_ASSERT_SAME(a_run_index_bounded, state_q == rsg_pkg::ST_RUN, ridx_q <= lim_q, "sort index ran past pass end")
	`RSG_ASSERT_SAME(a_beat_from_emit, result_strobe, $past(state_q == rsg_pkg::ST_EMIT), "result beat outside emission")
	`RSG_ASSERT_NEXT(a_run_ends_once, result_strobe && result.end_of_run, !result_strobe, "beat after end of run")

endmodule

// ----- test/sorted_run_checker.sv -----
// Checker for the record sort block: predicts every sorted run and compares it beat by beat.
`timescale 1ns / 100ps
module sorted_run_checker #(
	parameter int MAX_RECORDS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  rsg_pkg::in_t  item,
	input  logic          result_strobe,
	input  rsg_pkg::out_t result,
	output int            errors,
	output int            pending
);

	rsg_pkg::rec_t held [MAX_RECORDS];
	int            held_count = 0;
	logic          dropped = 1'b0;
	rsg_pkg::out_t expected_run [$];
	rsg_pkg::out_t want;
	int            mismatch_count = 0;

	task automatic report_field(input string field, input logic [15:0] exp_val,
			input logic [15:0] got_val);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val, got_val);
		mismatch_count++;
	endtask

	// Stores one accepted record; the final record of a set sorts the held records
	// and queues the whole run as expected beats.
	task automatic take_record(input rsg_pkg::in_t rec_in);
		rsg_pkg::rec_t rec;
		rsg_pkg::rec_t moving;
		rsg_pkg::out_t beat;
		int            j;
		rec.id = rec_in.record_id;
		rec.grade = (rec_in.grade_hundredths > rsg_pkg::GRADE_TOP) ?
			rsg_pkg::GRADE_TOP : rec_in.grade_hundredths;
		if (held_count < MAX_RECORDS) begin
			held[held_count] = rec;
			held_count++;
		end else begin
			dropped = 1'b1;
		end
		if (rec_in.last_record) begin
			// Insertion sort that moves a record up only past strictly lower grades,
			// so equal grades stay in arrival order.
			for (int i = 1; i < held_count; i++) begin
				moving = held[i];
				j = i;
				while (j > 0 && held[j - 1].grade < moving.grade) begin
					held[j] = held[j - 1];
					j--;
				end
				held[j] = moving;
			end
			for (int i = 0; i < held_count; i++) begin
				beat.sorted_id = held[i].id;
				beat.sorted_grade = held[i].grade;
				beat.end_of_run = (i == held_count - 1);
				beat.overflow_flag = dropped;
				expected_run.push_back(beat);
			end
			held_count = 0;
			dropped = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			dropped = 1'b0;
			expected_run.delete();
			mismatch_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (result_strobe) begin
				if (expected_run.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got id %0h grade %0d end %b ovf %b",
						$time, result.sorted_id, result.sorted_grade, result.end_of_run,
						result.overflow_flag);
					mismatch_count++;
				end else begin
					want = expected_run.pop_front();
					if (result.sorted_id !== want.sorted_id)
						report_field("sorted_id", want.sorted_id, result.sorted_id);
					if (result.sorted_grade !== want.sorted_grade)
						report_field("sorted_grade", 16'(want.sorted_grade),
							16'(result.sorted_grade));
					if (result.end_of_run !== want.end_of_run)
						report_field("end_of_run", 16'(want.end_of_run),
							16'(result.end_of_run));
					if (result.overflow_flag !== want.overflow_flag)
						report_field("overflow_flag", 16'(want.overflow_flag),
							16'(result.overflow_flag));
				end
			end
			if (start && !busy)
				take_record(item);
			errors <= mismatch_count;
			pending <= expected_run.size();
		end
	end

endmodule

// ----- test/tb.sv -----
// Testbench top for the record sort block: drives record sets and gives the verdict.
`timescale 1ns / 100ps
module tb;

	// The block is tested at its full store size.
	localparam int STORE_DEPTH = 64;
	// This margin covers what may still be in flight once nothing more
	// is expected.
	localparam int SETTLE_CYCLES = 40;
	// Bound on the wait for a full store to sort and emit its run.
	localparam int DRAIN_LIMIT = 20000;
	// Minimum number of records sent per random phase.
	localparam int PHASE_RECORDS = 8;

	logic          clk;
	logic          arst_n;
	logic          start;
	rsg_pkg::in_t  item;
	logic          busy;
	logic          result_strobe;
	rsg_pkg::out_t result;
	int            errors;
	int            pending;

	// Chance in percent that the sender leaves a gap before a beat.
	int   idle_pct;

	record_sort_by_grade #(
		.MAX_RECORDS(STORE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.result_strobe(result_strobe),
		.result(result)
	);

	sorted_run_checker #(
		.MAX_RECORDS(STORE_DEPTH)
	) run_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_strobe(result_strobe),
		.result(result),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs, well beyond the slowest correct run.
	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Offers one record and holds it until the block takes the beat. A gap with
	// start low may come first, depending on the current idle setting. start is
	// left high on return so back-to-back beats need no second assignment.
	task automatic send_record(input logic [15:0] rec_id, input logic [13:0] grade,
			input logic last);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		item <= '{record_id: rec_id, grade_hundredths: grade, last_record: last};
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Grades are mostly spread over the legal range; some are drawn from a few
	// coarse values so that ties are common, and some lie above 100.00 to hit
	// the saturation.
	function automatic logic [13:0] pick_grade();
		int roll;
		roll = $urandom_range(99);
		if (roll < 20)
			return 14'($urandom_range(4) * 2500);
		if (roll < 30)
			return 14'($urandom_range(16383, 10001));
		return 14'($urandom_range(10000));
	endfunction

	// Sends a well-formed set of n records, the last one flagged.
	task automatic send_set(input int n);
		for (int k = 0; k < n; k++)
			send_record(16'($urandom), pick_grade(), k == n - 1);
	endtask

	// Drops start and waits till all expected beats arrive or DRAIN_LIMIT is hit.
	// The first edge lets the checker's count catch up with the beat just taken.
	task automatic drain_runs();
		int waited;
		waited = 0;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	initial begin
		int set_size;
		int phase_sent;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets. A set of one record, with id and grade at their low end.
		send_record(16'h0000, 14'd0, 1'b1);
		// A set of one record with every bit set; the grade saturates to 100.00.
		send_record(16'hFFFF, 14'h3FFF, 1'b1);
		// Grades at and just around the top of the range, two of them tied after
		// saturation, plus a zero grade that must sink to the end.
		send_record(16'h5A5A, 14'd10001, 1'b0);
		send_record(16'h0000, 14'd0, 1'b0);
		send_record(16'hFFFF, 14'd10000, 1'b0);
		send_record(16'hA5A5, 14'd9999, 1'b1);
		// All grades equal: the run must come out in arrival order.
		send_record(16'h0001, 14'd5000, 1'b0);
		send_record(16'h0002, 14'd5000, 1'b0);
		send_record(16'h0003, 14'd5000, 1'b0);
		send_record(16'h0004, 14'd5000, 1'b1);
		// Rising grades, the case where every compare swaps.
		send_record(16'h0010, 14'd100, 1'b0);
		send_record(16'h0020, 14'd200, 1'b0);
		send_record(16'h0030, 14'd300, 1'b0);
		send_record(16'h0040, 14'd400, 1'b0);
		send_record(16'h0050, 14'd500, 1'b1);
		// Already in order, so no compare swaps.
		send_record(16'h1234, 14'd8000, 1'b0);
		send_record(16'h4321, 14'd7999, 1'b1);
		drain_runs();

		// Random sets in three idle settings: none, a sender that is idle most of
		// the time, and a lightly idle one. The receiver cannot stall, so there is
		// no receiver setting to vary. Each phase ends by draining all runs.
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 1) ? 81 : ((phase == 2) ? 25 : 0);
			// One oversized set: the store fills, later records are dropped, the
			// final one among them, and the whole run carries the overflow flag.
			// The small sets that follow must show the flag cleared again.
			if (phase == 2)
				send_set(STORE_DEPTH + 2);
			phase_sent = 0;
			while (phase_sent < PHASE_RECORDS) begin
				set_size = $urandom_range(1, 8);
				send_set(set_size);
				phase_sent += set_size;
			end
			drain_runs();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending != 0)
			$display("%0t: %0d expected beats never arrived", $time, pending);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/rsg_pkg.sv
rtl/core/rsg_store.sv
rtl/core/rsg_step.sv
rtl/core/record_sort_by_grade.sv
test/sorted_run_checker.sv
test/tb.sv
